// ----- hdl/bounded_channel_with_wait_queues_unit_defines.svh -----
// Assertion macros shared by the channel controller and datapath.
`ifndef BOUNDED_CHANNEL_WITH_WAIT_QUEUES_UNIT_DEFINES_SVH
`define BOUNDED_CHANNEL_WITH_WAIT_QUEUES_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define BCWQ_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
	else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define BCWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- hdl/bcwq_pkg.sv -----
// Shared types and constants of the bounded message channel.
`timescale 1ns / 1ps

package bcwq_pkg;

	// Fixed field widths.
	localparam int CAP_W   = 5;
	localparam int TID_W   = 3;
	localparam int VALUE_W = 32;

	// Default sizing of the value buffer and the wait lists.
	localparam int DEFAULT_BUFFER_DEPTH = 16;
	localparam int DEFAULT_THREAD_COUNT = 8;

	// Capacity after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Stream widths, rounded up to whole bytes.
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	// Register file.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_CAPACITY = 1'b0;

	// Request kinds.
	localparam logic FUNC_SEND = 1'b0;
	localparam logic FUNC_RECV = 1'b1;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

	// One result item.
	typedef struct packed {
		logic               ok;
		logic [VALUE_W-1:0] data;
		logic               block_caller;
		logic               wake_valid;
		logic [TID_W-1:0]   wake_thread;
	} result_t;

endpackage

// ----- hdl/bounded_channel_with_wait_queues_unit.sv -----
// A request is loaded on its transfer and executed in the execute state; its registered result
// is held valid in the respond state until it transfers. The controller runs this load, execute
// and respond sequence, so one request is in flight at a time.
// Reset (asynchronous): capacity 16, empty buffer and wait lists, pointers zero.
// Buffer and list entries are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module bounded_channel_with_wait_queues_unit #(
	parameter int BUFFER_DEPTH = bcwq_pkg::DEFAULT_BUFFER_DEPTH,
	parameter int THREAD_COUNT = bcwq_pkg::DEFAULT_THREAD_COUNT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Request stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// thread_present [0], thread_id [3:1], value [35:4], zero pad [39:36]
	input  logic [bcwq_pkg::IN_TDATA_W-1:0]   s_tdata,
	// func [0]
	input  logic                              s_tuser,
	// Result stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// ok [0], data [32:1], block_caller [33], wake_valid [34], wake_thread [37:35],
	// zero pad [39:38]
	output logic [bcwq_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// Configuration port.
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bcwq_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [bcwq_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [bcwq_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	logic [bcwq_pkg::CAP_W-1:0] capacity_q;
	logic                       reg_sel;
	bcwq_pkg::ctrl_cmd_t        cmd;
	bcwq_pkg::result_t          res;

	// Register decode on the word address.
	assign reg_sel = (paddr[2] == bcwq_pkg::REG_CAPACITY);
	assign pready  = 1'b1;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= bcwq_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			capacity_q <= pwdata[bcwq_pkg::CAP_W-1:0];
		end
	end

	// Read back.
	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = bcwq_pkg::APB_DATA_W'(capacity_q);
		end
	end

	bcwq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	bcwq_dpath #(
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.THREAD_COUNT (THREAD_COUNT)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.func           (s_tuser),
		.thread_present (s_tdata[0]),
		.thread_id      (s_tdata[3:1]),
		.value          (s_tdata[35:4]),
		.capacity       (capacity_q),
		.res            (res)
	);

	// Pack the result item.
	assign m_tdata = {2'b00, res.wake_thread, res.wake_valid, res.block_caller,
		res.data, res.ok};

endmodule

// ----- hdl/bcwq_ctrl.sv -----
// Controller state machine: load a request, execute it, hand out the result.
`timescale 1ns / 1ps
`include "bounded_channel_with_wait_queues_unit_defines.svh"

module bcwq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output bcwq_pkg::ctrl_cmd_t cmd
);

	bcwq_pkg::state_t state_q;
	bcwq_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcwq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bcwq_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = bcwq_pkg::ST_EXEC;
				end
			end
			bcwq_pkg::ST_EXEC: begin
				state_d = bcwq_pkg::ST_RESP;
			end
			bcwq_pkg::ST_RESP: begin
				if (m_tready) begin
					state_d = bcwq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bcwq_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		cmd      = '0;
		case (state_q)
			bcwq_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			bcwq_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			bcwq_pkg::ST_RESP: begin
				m_tvalid = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// Only one request is in flight at a time.
	`BCWQ_ASSERT_ALWAYS(a_one_in_flight, !(s_tready && m_tvalid), "accepting while a result waits")
	// An executed request always produces a result in the next cycle.
	`BCWQ_ASSERT_NEXT(a_exec_to_resp, cmd.exec, m_tvalid, "no result after execute")
	// A request is loaded only on its transfer.
	`BCWQ_ASSERT_ALWAYS(a_load_on_transfer, !cmd.load || (s_tvalid && s_tready), "load without transfer")

endmodule

// ----- hdl/bcwq_dpath.sv -----
// Datapath: value ring buffer, waiting sender and receiver lists, result registers.
`timescale 1ns / 1ps
`include "bounded_channel_with_wait_queues_unit_defines.svh"

module bcwq_dpath #(
	parameter int BUFFER_DEPTH = bcwq_pkg::DEFAULT_BUFFER_DEPTH,
	parameter int THREAD_COUNT = bcwq_pkg::DEFAULT_THREAD_COUNT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bcwq_pkg::ctrl_cmd_t          cmd,
	input  logic                         func,
	input  logic                         thread_present,
	input  logic [bcwq_pkg::TID_W-1:0]   thread_id,
	input  logic [bcwq_pkg::VALUE_W-1:0] value,
	input  logic [bcwq_pkg::CAP_W-1:0]   capacity,
	output bcwq_pkg::result_t            res
);

	localparam int PTR_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
	localparam int IDX_W  = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
	localparam int CNT_W  = $clog2(THREAD_COUNT + 1);
	localparam int CMP_W  = (FILL_W > bcwq_pkg::CAP_W) ? FILL_W : bcwq_pkg::CAP_W;

	// Captured request.
	logic                         func_q;
	logic                         present_q;
	logic [bcwq_pkg::TID_W-1:0]   tid_q;
	logic [bcwq_pkg::VALUE_W-1:0] value_q;

	// Channel state.
	logic [bcwq_pkg::VALUE_W-1:0] value_mem [BUFFER_DEPTH];
	logic [PTR_W-1:0]             rd_ptr_q;
	logic [PTR_W-1:0]             wr_ptr_q;
	logic [FILL_W-1:0]            fill_q;
	logic [bcwq_pkg::TID_W-1:0]   snd_list_q [THREAD_COUNT];
	logic [bcwq_pkg::TID_W-1:0]   rcv_list_q [THREAD_COUNT];
	logic [CNT_W-1:0]             snd_cnt_q;
	logic [CNT_W-1:0]             rcv_cnt_q;

	// Result registers.
	logic                         ok_q;
	logic                         recv_q;
	logic                         blk_q;
	logic                         wv_q;
	logic [bcwq_pkg::TID_W-1:0]   wt_q;
	logic [bcwq_pkg::VALUE_W-1:0] rdata_q;

	// Decision logic.
	logic [CMP_W-1:0] cap_x;
	logic [CMP_W-1:0] depth_x;
	logic [CMP_W-1:0] cap_eff;
	logic [CMP_W-1:0] fill_x;
	logic             is_send;
	logic             full;
	logic             empty;
	logic             send_ok;
	logic             recv_ok;
	logic             snd_push;
	logic             rcv_push;
	logic             snd_pop;
	logic             rcv_pop;
	logic [PTR_W-1:0] rd_ptr_nx;
	logic [PTR_W-1:0] wr_ptr_nx;

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q    <= func;
			present_q <= thread_present;
			tid_q     <= thread_id;
			value_q   <= value;
		end
	end

	// Fill against the clamped capacity, and the wait-list decisions.
	always_comb begin
		cap_x    = CMP_W'(capacity);
		depth_x  = CMP_W'(BUFFER_DEPTH);
		cap_eff  = (cap_x > depth_x) ? depth_x : cap_x;
		fill_x   = CMP_W'(fill_q);
		is_send  = (func_q == bcwq_pkg::FUNC_SEND);
		full     = (fill_x >= cap_eff);
		empty    = (fill_q == '0);
		send_ok  = is_send && !full;
		recv_ok  = !is_send && !empty;
		snd_push = is_send && full && present_q && (snd_cnt_q < CNT_W'(THREAD_COUNT));
		rcv_push = !is_send && empty && present_q && (rcv_cnt_q < CNT_W'(THREAD_COUNT));
		snd_pop  = recv_ok && (snd_cnt_q != '0);
		rcv_pop  = send_ok && (rcv_cnt_q != '0);
		rd_ptr_nx = (rd_ptr_q == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
		wr_ptr_nx = (wr_ptr_q == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
	end

	// Value buffer: write on a good send, registered read at the read pointer.
	always_ff @(posedge clk) begin
		if (cmd.exec && send_ok) begin
			value_mem[wr_ptr_q] <= value_q;
		end
		if (cmd.exec) begin
			rdata_q <= value_mem[rd_ptr_q];
		end
	end

	// Pointers, fill and list counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q  <= '0;
			wr_ptr_q  <= '0;
			fill_q    <= '0;
			snd_cnt_q <= '0;
			rcv_cnt_q <= '0;
		end else if (cmd.exec) begin
			if (send_ok) begin
				wr_ptr_q <= wr_ptr_nx;
				fill_q   <= fill_q + 1'b1;
			end
			if (recv_ok) begin
				rd_ptr_q <= rd_ptr_nx;
				fill_q   <= fill_q - 1'b1;
			end
			if (snd_push) begin
				snd_cnt_q <= snd_cnt_q + 1'b1;
			end else if (snd_pop) begin
				snd_cnt_q <= snd_cnt_q - 1'b1;
			end
			if (rcv_push) begin
				rcv_cnt_q <= rcv_cnt_q + 1'b1;
			end else if (rcv_pop) begin
				rcv_cnt_q <= rcv_cnt_q - 1'b1;
			end
		end
	end

	// Waiting senders: append at the tail, shift all entries on a wake.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (snd_push) begin
				snd_list_q[snd_cnt_q[IDX_W-1:0]] <= tid_q;
			end else if (snd_pop) begin
				for (int i = 0; i < THREAD_COUNT - 1; i++) begin
					snd_list_q[i] <= snd_list_q[i+1];
				end
			end
		end
	end

	// Waiting receivers, handled the same way.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (rcv_push) begin
				rcv_list_q[rcv_cnt_q[IDX_W-1:0]] <= tid_q;
			end else if (rcv_pop) begin
				for (int i = 0; i < THREAD_COUNT - 1; i++) begin
					rcv_list_q[i] <= rcv_list_q[i+1];
				end
			end
		end
	end

	// Result flags and the woken thread.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			ok_q   <= send_ok || recv_ok;
			recv_q <= !is_send;
			blk_q  <= snd_push || rcv_push;
			wv_q   <= snd_pop || rcv_pop;
			if (snd_pop) begin
				wt_q <= snd_list_q[0];
			end else if (rcv_pop) begin
				wt_q <= rcv_list_q[0];
			end else begin
				wt_q <= '0;
			end
		end
	end

	// Received data shows only on a successful receive.
	always_comb begin
		res.ok           = ok_q;
		res.data         = (ok_q && recv_q) ? rdata_q : '0;
		res.block_caller = blk_q;
		res.wake_valid   = wv_q;
		res.wake_thread  = wt_q;
	end

	// The buffer never holds more than its depth.
	`BCWQ_ASSERT_ALWAYS(a_fill_bound, fill_q <= FILL_W'(BUFFER_DEPTH), "fill above depth")
	// The wait lists never hold more than the thread count.
	`BCWQ_ASSERT_ALWAYS(a_snd_bound, snd_cnt_q <= CNT_W'(THREAD_COUNT), "sender list overflow")
	`BCWQ_ASSERT_ALWAYS(a_rcv_bound, rcv_cnt_q <= CNT_W'(THREAD_COUNT), "receiver list overflow")
	// A request either succeeds or blocks its caller, never both.
	`BCWQ_ASSERT_NEXT(a_ok_or_block, cmd.exec, !(ok_q && blk_q), "ok and block together")

endmodule

// ----- tb/sv/tb_bounded_channel_with_wait_queues_unit.sv -----
// Self-checking testbench for the bounded message channel with blocked-thread wait lists.
`timescale 1ns / 1ps

module tb_bounded_channel_with_wait_queues_unit;
	import bcwq_pkg::*;

	localparam int BUF_DEPTH = DEFAULT_BUFFER_DEPTH;
	localparam int TH_COUNT  = DEFAULT_THREAD_COUNT;

	// Byte addresses of the register file; index one is unmapped.
	localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY = APB_ADDR_W'(4 * REG_CAPACITY);
	localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = APB_ADDR_W'(4);

	// One request as the channel sees it.
	typedef struct {
		logic               func;
		logic               present;
		logic [TID_W-1:0]   tid;
		logic [VALUE_W-1:0] value;
	} chan_req_t;

	typedef enum logic {ROW_REQUEST, ROW_REG_WRITE} row_kind_t;

	// One row of the directed table.
	typedef struct {
		row_kind_t                kind;
		chan_req_t                req;
		logic [APB_ADDR_W-1:0]    addr;
		logic [APB_DATA_W-1:0]    wdata;
		bit                       typed;
		result_t                  want;
	} plan_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata;
	logic                    s_tuser;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_TDATA_W-1:0]  m_tdata;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [APB_ADDR_W-1:0]   paddr;
	logic [APB_DATA_W-1:0]   pwdata;
	logic [APB_DATA_W-1:0]   prdata;
	logic                    pready;

	// Shadow copy of the channel state.
	logic [CAP_W-1:0]   cap_reg;
	logic [VALUE_W-1:0] chan_buf [BUF_DEPTH];
	int unsigned        rd_ptr;
	int unsigned        wr_ptr;
	int unsigned        fill;
	logic [TID_W-1:0]   snd_wait [TH_COUNT];
	int unsigned        snd_cnt;
	logic [TID_W-1:0]   rcv_wait [TH_COUNT];
	int unsigned        rcv_cnt;

	result_t   pending_results [$];
	plan_row_t plan [$];
	int        errors;
	bit        steady;

	bounded_channel_with_wait_queues_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#2000000;
		$display("tb_bounded_channel_with_wait_queues_unit failed");
		$finish;
	end

	// Result-side backpressure, off while the steady stretch runs.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 33);
		end
	end

	// Computes the result of one request and updates the shadow state.
	function automatic result_t channel_predict(chan_req_t r);
		result_t     res;
		int unsigned lim;
		int          i;
		res = '0;
		lim = (cap_reg > BUF_DEPTH) ? BUF_DEPTH : cap_reg;
		if (r.func == FUNC_SEND) begin
			if (fill >= lim) begin
				// Full: queue the sender if there is one and its list has room.
				if (r.present && snd_cnt < TH_COUNT) begin
					snd_wait[snd_cnt] = r.tid;
					snd_cnt++;
					res.block_caller = 1'b1;
				end
			end else begin
				chan_buf[wr_ptr] = r.value;
				wr_ptr = (wr_ptr == BUF_DEPTH - 1) ? 0 : wr_ptr + 1;
				fill++;
				res.ok = 1'b1;
				if (rcv_cnt > 0) begin
					res.wake_valid = 1'b1;
					res.wake_thread = rcv_wait[0];
					for (i = 1; i < TH_COUNT; i++)
						rcv_wait[i-1] = rcv_wait[i];
					rcv_cnt--;
				end
			end
		end else begin
			if (fill == 0) begin
				// Empty: queue the receiver if there is one and its list has room.
				if (r.present && rcv_cnt < TH_COUNT) begin
					rcv_wait[rcv_cnt] = r.tid;
					rcv_cnt++;
					res.block_caller = 1'b1;
				end
			end else begin
				res.data = chan_buf[rd_ptr];
				rd_ptr = (rd_ptr == BUF_DEPTH - 1) ? 0 : rd_ptr + 1;
				fill--;
				res.ok = 1'b1;
				if (snd_cnt > 0) begin
					res.wake_valid = 1'b1;
					res.wake_thread = snd_wait[0];
					for (i = 1; i < TH_COUNT; i++)
						snd_wait[i-1] = snd_wait[i];
					snd_cnt--;
				end
			end
		end
		return res;
	endfunction

	// Adds a request row; a typed row carries its own expected result.
	function automatic void plan_request(logic f, logic p, logic [TID_W-1:0] t,
			logic [VALUE_W-1:0] v, bit typed = 1'b0, logic ok = 1'b0,
			logic [VALUE_W-1:0] d = '0, logic blk = 1'b0, logic wv = 1'b0,
			logic [TID_W-1:0] wt = '0);
		plan_row_t row;
		row.kind = ROW_REQUEST;
		row.req = '{func: f, present: p, tid: t, value: v};
		row.addr = '0;
		row.wdata = '0;
		row.typed = typed;
		row.want = '{ok: ok, data: d, block_caller: blk, wake_valid: wv, wake_thread: wt};
		plan.push_back(row);
	endfunction

	function automatic void plan_reg_write(logic [APB_ADDR_W-1:0] a, logic [APB_DATA_W-1:0] d);
		plan_row_t row;
		row = '{kind: ROW_REG_WRITE, req: '{func: FUNC_SEND, present: 1'b0, tid: '0, value: '0},
			addr: a, wdata: d, typed: 1'b0, want: '0};
		plan.push_back(row);
	endfunction

	// Offers one request, with random gaps, and records its expected result on transfer.
	task automatic push_request(chan_req_t r, bit typed, result_t want);
		result_t res;
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 33) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.func;
		s_tdata <= {4'b0, r.value, r.tid, r.present};
		do @(posedge clk); while (!s_tready);
		res = channel_predict(r);
		pending_results.push_back(typed ? want : res);
	endtask

	task automatic stop_requests();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle.
	task automatic reg_write(logic [APB_ADDR_W-1:0] a, logic [APB_DATA_W-1:0] d);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (a == ADDR_CAPACITY)
			cap_reg = d[CAP_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Reads the capacity register back and compares it with the shadow copy.
	task automatic check_capacity();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_CAPACITY;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DATA_W'(cap_reg)) begin
			$error("capacity: expected %0d, actual %0d", cap_reg, prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Result checker: every result transfer against the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no request outstanding: tdata %h", m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[0] !== want.ok) begin
					$error("ok: expected %0d, actual %0d", want.ok, m_tdata[0]);
					errors++;
				end
				if (m_tdata[32:1] !== want.data) begin
					$error("data: expected %h, actual %h", want.data, m_tdata[32:1]);
					errors++;
				end
				if (m_tdata[33] !== want.block_caller) begin
					$error("block_caller: expected %0d, actual %0d",
						want.block_caller, m_tdata[33]);
					errors++;
				end
				if (m_tdata[34] !== want.wake_valid) begin
					$error("wake_valid: expected %0d, actual %0d", want.wake_valid, m_tdata[34]);
					errors++;
				end
				if (m_tdata[37:35] !== want.wake_thread) begin
					$error("wake_thread: expected %0d, actual %0d",
						want.wake_thread, m_tdata[37:35]);
					errors++;
				end
			end
		end
	end

	// Stimulus: directed table, then random phases over several capacities.
	initial begin
		logic [CAP_W-1:0] phase_cap [8];
		int               recv_pct [8];
		chan_req_t        r;
		int               t;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = FUNC_SEND;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		steady = 1'b0;
		errors = 0;
		cap_reg = CAP_RESET;
		rd_ptr = 0;
		wr_ptr = 0;
		fill = 0;
		snd_cnt = 0;
		rcv_cnt = 0;
		phase_cap = '{5'd16, 5'd1, 5'd0, 5'd2, 5'd31, 5'd17, 5'd3, 5'd8};
		recv_pct = '{30, 50, 70, 20, 50, 60, 40, 50};

		// Empty channel: a receive with a thread blocks, without a thread it just fails.
		plan_request(FUNC_RECV, 1'b1, 3'd7, '0, 1'b1, 1'b0, '0, 1'b1, 1'b0, 3'd0);
		plan_request(FUNC_RECV, 1'b0, 3'd3, '0, 1'b1, 1'b0, '0, 1'b0, 1'b0, 3'd0);
		// A send wakes the waiting receiver; extreme values pass through.
		plan_request(FUNC_SEND, 1'b1, 3'd0, 32'h7FFF_FFFF, 1'b1, 1'b1, '0, 1'b0, 1'b1, 3'd7);
		plan_request(FUNC_SEND, 1'b0, 3'd0, 32'h8000_0000, 1'b1, 1'b1, '0, 1'b0, 1'b0, 3'd0);
		plan_request(FUNC_RECV, 1'b1, 3'd2, '0, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0, 3'd0);
		plan_request(FUNC_SEND, 1'b1, 3'd1, 32'hFFFF_FFFF);
		// Capacity zero below the fill: sends block, the same thread twice.
		plan_reg_write(ADDR_CAPACITY, 32'd0);
		plan_request(FUNC_SEND, 1'b1, 3'd5, 32'd1, 1'b1, 1'b0, '0, 1'b1, 1'b0, 3'd0);
		plan_request(FUNC_SEND, 1'b1, 3'd5, 32'd2, 1'b1, 1'b0, '0, 1'b1, 1'b0, 3'd0);
		plan_request(FUNC_RECV, 1'b0, 3'd0, '0, 1'b1, 1'b1, 32'h8000_0000, 1'b0, 1'b1, 3'd5);
		plan_request(FUNC_RECV, 1'b1, 3'd4, '0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1, 3'd5);
		// A write to an unmapped register leaves capacity at zero.
		plan_reg_write(ADDR_UNMAPPED, 32'd16);
		plan_request(FUNC_SEND, 1'b1, 3'd6, 32'd3, 1'b1, 1'b0, '0, 1'b1, 1'b0, 3'd0);
		// Capacity above depth; then fill the receiver list and overflow it.
		plan_reg_write(ADDR_CAPACITY, 32'd31);
		for (t = 0; t < TH_COUNT; t++)
			plan_request(FUNC_RECV, 1'b1, TID_W'(t), '0);
		plan_request(FUNC_RECV, 1'b1, 3'd3, '0, 1'b1, 1'b0, '0, 1'b0, 1'b0, 3'd0);
		plan_request(FUNC_SEND, 1'b1, 3'd2, 32'd0);
		plan_request(FUNC_RECV, 1'b0, 3'd1, '0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		check_capacity();

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG_WRITE) begin
				stop_requests();
				wait_drained();
				reg_write(plan[i].addr, plan[i].wdata);
				check_capacity();
			end else begin
				push_request(plan[i].req, plan[i].typed, plan[i].want);
			end
		end

		// Random phases; each starts from an idle channel with a new capacity.
		foreach (phase_cap[p]) begin
			stop_requests();
			wait_drained();
			reg_write(ADDR_CAPACITY, APB_DATA_W'(phase_cap[p]));
			check_capacity();
			steady = (p == 4);
			for (int n = 0; n < 70; n++) begin
				r.func = ($urandom_range(0, 99) < recv_pct[p]) ? FUNC_RECV : FUNC_SEND;
				r.present = ($urandom_range(0, 9) != 0);
				r.tid = TID_W'($urandom_range(0, TH_COUNT - 1));
				case ($urandom_range(0, 9))
					0: r.value = 32'h7FFF_FFFF;
					1: r.value = 32'h8000_0000;
					2: r.value = 32'h0000_0000;
					3: r.value = 32'hFFFF_FFFF;
					default: r.value = $urandom;
				endcase
				// Hold off mid-phase until every outstanding result has come back.
				if (p == 5 && n == 35) begin
					stop_requests();
					wait_drained();
				end
				push_request(r, 1'b0, '0);
			end
			steady = 1'b0;
		end

		stop_requests();
		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("tb_bounded_channel_with_wait_queues_unit passed");
		end else begin
			$display("tb_bounded_channel_with_wait_queues_unit failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/bcwq_pkg.sv
hdl/bcwq_ctrl.sv
hdl/bcwq_dpath.sv
hdl/bounded_channel_with_wait_queues_unit.sv
tb/sv/tb_bounded_channel_with_wait_queues_unit.sv
